>>> rtl/core/zcb_pkg.sv
// Shared types, constants and the on/off pattern table of the burst-fire power modulator.
`default_nettype none

package zcb_pkg;

    // Power units that make up one mode step.
    localparam int unsigned UNITS_PER_MODE = 15;
    // Highest power mode (table row).
    localparam logic [3:0] MODE_MAX = 4'd8;
    // Number of table columns; the last column index is COLS - 1.
    localparam logic [3:0] COLS = 4'd9;
    localparam logic [3:0] COL_LAST = 4'd8;
    // First column of the offset phase.
    localparam logic [3:0] OFFSET_START = 4'd1;

    // Reciprocal of 15 scaled by 2^16, rounded up so that the quotient is exact
    // for every sum of an 8-bit power and a remainder below 15.
    localparam int unsigned DIV_SHIFT = 16;
    localparam logic [12:0] DIV_RECIP = 13'((65536 + UNITS_PER_MODE - 1) / UNITS_PER_MODE + 1);

    // On/off pattern per mode; bit n is the drive level at column n.
    localparam logic [8:0] PATTERN [0:8] = '{
        9'b000000000,
        9'b000010000,
        9'b001000100,
        9'b001010010,
        9'b010101010,
        9'b110110101,
        9'b111011101,
        9'b111110111,
        9'b111111111
    };

    // Modulator state carried from one crossing to the next.
    typedef struct packed {
        logic [3:0] crossing_index;
        logic       offset_phase;
        logic       round_finished;
        logic [3:0] mode;
        logic [3:0] carry;
    } zcb_state_t;

    // One crossing request.
    typedef struct packed {
        logic [7:0] force_power;
        logic [7:0] power_request;
        logic [1:0] relay_state;
        logic       fault_present;
    } zcb_req_t;

    // One crossing result.
    typedef struct packed {
        logic       drive_on;
        logic [3:0] power_mode;
        logic       round_done;
    } zcb_result_t;

endpackage

`default_nettype wire

>>> rtl/core/zcb_step.sv
// Per-crossing logic: mode refresh, pattern lookup and round sequencing.
`default_nettype none

module zcb_step (
    input  wire zcb_pkg::zcb_state_t  state_cur,
    input  wire zcb_pkg::zcb_req_t    req,
    output zcb_pkg::zcb_state_t       state_next,
    output zcb_pkg::zcb_result_t      result
);

    logic        enable;
    logic [7:0]  power;
    logic [8:0]  total;
    logic [21:0] product;
    logic [4:0]  quotient;
    logic [8:0]  quotient_x15;
    logic [8:0]  remainder;
    logic [3:0]  mode_new;
    logic [3:0]  mode_used;
    logic [3:0]  column;
    logic [3:0]  index_inc;
    zcb_pkg::zcb_state_t state_upd;

    // Drive is allowed without a fault when forced or when a heating relay state is set.
    assign enable = !req.fault_present && ((req.force_power != 8'd0) || (req.relay_state != 2'd0));

    // Divide power plus carried error by fifteen through the scaled reciprocal.
    assign power        = (req.force_power != 8'd0) ? req.force_power : req.power_request;
    assign total        = {1'b0, power} + {5'd0, state_cur.carry};
    assign product      = {13'd0, total} * {9'd0, zcb_pkg::DIV_RECIP};
    assign quotient     = product[zcb_pkg::DIV_SHIFT +: 5];
    assign quotient_x15 = {quotient, 4'd0} - {4'd0, quotient};
    assign remainder    = total - quotient_x15;
    assign mode_new     = (quotient > {1'b0, zcb_pkg::MODE_MAX}) ? zcb_pkg::MODE_MAX
                                                                 : quotient[3:0];

    // Next state and result of a crossing; a disabled crossing clears both.
    always_comb begin
        state_upd = state_cur;
        if (state_cur.round_finished) begin
            state_upd.round_finished = 1'b0;
            state_upd.carry          = remainder[3:0];
            state_upd.mode           = mode_new;
        end

        mode_used = (state_upd.mode > zcb_pkg::MODE_MAX) ? zcb_pkg::MODE_MAX : state_upd.mode;
        column    = (state_cur.crossing_index >= zcb_pkg::COLS) ? zcb_pkg::COL_LAST
                                                                : state_cur.crossing_index;
        index_inc = state_cur.crossing_index + 4'd1;

        result.drive_on   = zcb_pkg::PATTERN[mode_used][column];
        result.power_mode = mode_used;
        result.round_done = 1'b0;

        state_upd.crossing_index = index_inc;
        // Offset phase ends after column 8, plain phase after column 7.
        if (state_cur.offset_phase) begin
            if (index_inc == zcb_pkg::COLS) begin
                state_upd.crossing_index = 4'd0;
                state_upd.offset_phase   = 1'b0;
                state_upd.round_finished = 1'b1;
                result.round_done        = 1'b1;
            end
        end else begin
            if (index_inc == zcb_pkg::COL_LAST) begin
                state_upd.crossing_index = zcb_pkg::OFFSET_START;
                state_upd.offset_phase   = 1'b1;
                state_upd.round_finished = 1'b1;
                result.round_done        = 1'b1;
            end
        end

        // A disabled crossing turns the drive off and clears all state.
        if (!enable) begin
            state_next = '0;
            result     = '0;
        end else begin
            state_next = state_upd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/zero_cross_burst_power_modulator.sv
// Top level of the burst-fire zero-cross power modulator with stream ports.
// A crossing request's result is registered and shown in the cycle after acceptance.
// Throughput: one request per cycle unless stalled; the output frees as it is taken.
// A request whose tuser flag is low is an idle tick and yields no result.
// Reset (aresetn low, synchronous) clears the round state and empties the output register.
`default_nettype none

module zero_cross_burst_power_modulator (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    // [7:0] force_power, [15:8] power_request, [17:16] relay_state, [18] fault_present
    input  wire [23:0] s_tdata,
    // [0] line_cross
    input  wire        s_tuser,
    output logic       m_tvalid,
    input  wire        m_tready,
    // [0] drive_on, [4:1] power_mode
    output logic [7:0] m_tdata,
    // round_done
    output logic       m_tlast
);

    zcb_pkg::zcb_state_t  state_reg;
    zcb_pkg::zcb_state_t  state_next;
    zcb_pkg::zcb_req_t    req;
    zcb_pkg::zcb_result_t result;
    zcb_pkg::zcb_result_t result_reg;
    logic                 m_valid_reg;
    logic                 s_fire;
    logic                 cross_fire;

    assign req.force_power   = s_tdata[7:0];
    assign req.power_request = s_tdata[15:8];
    assign req.relay_state   = s_tdata[17:16];
    assign req.fault_present = s_tdata[18];

    // A new request enters whenever the output register is empty or being drained.
    assign s_tready   = !m_valid_reg || m_tready;
    assign s_fire     = s_tvalid && s_tready;
    assign cross_fire = s_fire && s_tuser;

    zcb_step u_step (
        .state_cur  (state_reg),
        .req        (req),
        .state_next (state_next),
        .result     (result)
    );

    // Round state advances only on crossing requests.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (cross_fire) begin
            state_reg <= state_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= cross_fire;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (cross_fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, result_reg.power_mode, result_reg.drive_on};
    assign m_tlast  = result_reg.round_done;

    // The column index never leaves the table.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.crossing_index <= zcb_pkg::COL_LAST)
        else $error("crossing index beyond the last column");

    // The offset phase never starts at column zero.
    a_offset_col: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.offset_phase |-> (state_reg.crossing_index != 4'd0))
        else $error("offset phase at column zero");

    // Carried error stays below one mode step and the mode below the cap.
    a_carry_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.carry < 4'd15) && (state_reg.mode <= zcb_pkg::MODE_MAX))
        else $error("carry or mode out of range");

    // A crossing that ends a round leaves a mode refresh pending.
    a_round_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (cross_fire && result.round_done) |=> state_reg.round_finished)
        else $error("round ended without a pending mode refresh");

    // A reported round end always restarts at column zero or one.
    a_round_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cross_fire && result.round_done) |=>
        ((state_reg.crossing_index == 4'd0) || (state_reg.crossing_index == 4'd1)))
        else $error("round restarted at a wrong column");

endmodule

`default_nettype wire
